// ===== hdl/tpm_pkg.sv =====
// Shared types and constants for the tree path maximum alpha block.
`timescale 1ns / 1ps
`default_nettype none

package tpm_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int NODE_W     = 10;
    localparam int DEPTH_W    = 10;
    localparam int COST_W     = 32;
    localparam int ALPHA_W    = 32;
    localparam int STEP_LIMIT = 2 * NODE_COUNT + 2;
    localparam int STEP_W     = $clog2(STEP_LIMIT + 1);

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic CFG_EXCLUDED_NODE = 1'b0;
    localparam logic CFG_EXCLUDED_COST = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0]  parent;
        logic [DEPTH_W-1:0] depth;
        logic [COST_W-1:0]  cost;
    } node_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_WALK,
        ST_LAST,
        ST_RESULT
    } tpm_state_t;

endpackage

`default_nettype wire

// ===== hdl/tpm_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module tpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== hdl/tree_path_max_alpha.sv =====
// Top level: spanning tree table, upward path walk and alpha result.
//
//  channel  | handshake          | beat contents
//  ---------+--------------------+-------------------------------------------
//  in       | in_valid/in_stall  | action, node_a, node_b, is_root, edge_cost
//  out      | out_valid/out_stall| alpha, infinite
//  cfg      | cfg_write          | cfg_index, cfg_data
//
// Root load: written as the beat is taken. Child load: parent depth read, then write.
// Query: a self pair, parent link or excluded node is settled at the check; otherwise
// the walk takes s tree steps, one node-table read per step, where s <= 2*NODE_COUNT+2,
// plus a final edge pair when the walk meets at two distinct siblings.
// Reset clears control and configuration; the node table is not cleared.
// A waiting result sits in the output register while the next beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module tree_path_max_alpha
    import tpm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     action,
    input  logic [NODE_W-1:0]        node_a,
    input  logic [NODE_W-1:0]        node_b,
    input  logic                     is_root,
    input  logic signed [COST_W-1:0] edge_cost,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [ALPHA_W-1:0]       alpha,
    output logic                     infinite,
    input  logic                     cfg_write,
    input  logic                     cfg_index,
    input  logic [COST_W-1:0]        cfg_data
);

    tpm_state_t state_reg, state_next;

    logic [NODE_W-1:0]  a_reg, a_next;
    logic [NODE_W-1:0]  b_reg, b_next;
    logic [COST_W-1:0]  cost_reg, cost_next;
    logic [NODE_W-1:0]  n1_reg, n1_next;
    logic [NODE_W-1:0]  n2_reg, n2_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic               have_reg, have_next;
    logic [COST_W-1:0]  beta_reg, beta_next;
    logic               inf_reg, inf_next;
    logic               out_valid_reg, out_valid_next;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic               infinite_reg, infinite_next;
    logic [NODE_W-1:0]  ex_node_reg;
    logic [COST_W-1:0]  ex_cost_reg;

    logic               in_accept;
    logic               wr_en;
    logic [NODE_W-1:0]  wr_addr;
    node_entry_t        wr_entry;
    node_entry_t        e1;
    node_entry_t        e2;

    logic               cand_en;
    logic               cand_force;
    logic [DEPTH_W-1:0] cand_depth;
    logic [COST_W-1:0]  cand_cost;
    logic               cand_take;

    logic signed [COST_W:0] diff;
    logic                   final_inf;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    tpm_ram #(
        .WIDTH ($bits(node_entry_t)),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_entry),
        .rd_addr_a (n1_next),
        .rd_data_a (e1),
        .rd_addr_b (n2_next),
        .rd_data_b (e2)
    );

    // shared running-maximum unit
    assign cand_take = cand_en && (cand_force || (cand_depth != '0 &&
                       (!have_reg || $signed(cand_cost) > $signed(beta_reg))));

    assign diff      = $signed({cost_reg[COST_W-1], cost_reg})
                     - $signed({beta_reg[COST_W-1], beta_reg});
    assign final_inf = inf_reg || !have_reg;

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cost_next      = cost_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        steps_next     = steps_reg;
        inf_next       = inf_reg;
        out_valid_next = out_valid_reg && out_stall;
        alpha_next     = alpha_reg;
        infinite_next  = infinite_reg;
        wr_en          = 1'b0;
        wr_addr        = a_reg;
        wr_entry       = '{parent: b_reg, depth: e2.depth + DEPTH_W'(1), cost: cost_reg};
        cand_en        = 1'b0;
        cand_force     = 1'b0;
        cand_depth     = e1.depth;
        cand_cost      = e1.cost;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    a_next     = node_a;
                    b_next     = node_b;
                    cost_next  = edge_cost;
                    n1_next    = node_a;
                    n2_next    = node_b;
                    steps_next = '0;
                    inf_next   = 1'b0;
                    if (action == ACT_QUERY)
                    begin
                        state_next = ST_CHECK;
                    end
                    else if (is_root)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = node_a;
                        wr_entry = '{parent: node_a, depth: '0, cost: '0};
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                wr_en      = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CHECK:
            begin
                if (a_reg == b_reg)
                begin
                    inf_next   = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (e1.parent == b_reg)
                begin
                    cand_en    = 1'b1;
                    cand_force = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (e2.parent == a_reg)
                begin
                    cand_en    = 1'b1;
                    cand_force = 1'b1;
                    cand_cost  = e2.cost;
                    state_next = ST_RESULT;
                end
                else if (a_reg == ex_node_reg || b_reg == ex_node_reg)
                begin
                    cand_en    = 1'b1;
                    cand_force = 1'b1;
                    cand_cost  = ex_cost_reg;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (e1.parent != e2.parent)
                begin
                    if (steps_reg < STEP_W'(STEP_LIMIT))
                    begin
                        cand_en    = 1'b1;
                        steps_next = steps_reg + STEP_W'(1);
                        if (e1.depth > e2.depth)
                        begin
                            n1_next = e1.parent;
                        end
                        else
                        begin
                            cand_depth = e2.depth;
                            cand_cost  = e2.cost;
                            n2_next    = e2.parent;
                        end
                    end
                    else
                    begin
                        inf_next   = 1'b1;
                        state_next = ST_RESULT;
                    end
                end
                else if (n1_reg != n2_reg)
                begin
                    cand_en    = 1'b1;
                    state_next = ST_LAST;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_LAST:
            begin
                cand_en    = 1'b1;
                cand_depth = e2.depth;
                cand_cost  = e2.cost;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    infinite_next  = final_inf;
                    if (final_inf)
                    begin
                        alpha_next = '1;
                    end
                    else if (!diff[COST_W] && diff != '0)
                    begin
                        alpha_next = diff[ALPHA_W-1:0];
                    end
                    else
                    begin
                        alpha_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        have_next = have_reg;
        beta_next = beta_reg;
        if (state_reg == ST_IDLE && in_accept)
        begin
            have_next = 1'b0;
        end
        else if (cand_take)
        begin
            have_next = 1'b1;
            beta_next = cand_cost;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            steps_reg     <= '0;
            have_reg      <= 1'b0;
            inf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            ex_node_reg   <= '0;
            ex_cost_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            have_reg      <= have_next;
            inf_reg       <= inf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_EXCLUDED_NODE: ex_node_reg <= cfg_data[NODE_W-1:0];
                    CFG_EXCLUDED_COST: ex_cost_reg <= cfg_data;
                    default:           ex_node_reg <= ex_node_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        cost_reg     <= cost_next;
        n1_reg       <= n1_next;
        n2_reg       <= n2_next;
        beta_reg     <= beta_next;
        alpha_reg    <= alpha_next;
        infinite_reg <= infinite_next;
    end

    assign out_valid = out_valid_reg;
    assign alpha     = alpha_reg;
    assign infinite  = infinite_reg;

    a_result_from_result_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_RESULT)
        else $error("result beat raised outside the result state");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= STEP_W'(STEP_LIMIT))
        else $error("walk step count beyond limit");

    a_last_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LAST |-> n1_reg != n2_reg)
        else $error("final edge pair taken on a single node");

    a_infinite_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && infinite_reg |-> alpha_reg == '1)
        else $error("infinite result without all-ones alpha");

    a_load_no_query: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && action == ACT_LOAD |=> state_reg == ST_LOAD || state_reg == ST_IDLE)
        else $error("load beat entered the query path");

endmodule

`default_nettype wire

// ===== sim/alpha_checker.sv =====
// Checker for tree_path_max_alpha: tracks the tree tables, predicts each alpha beat and compares.
`timescale 1ns / 1ps

module alpha_checker
    import tpm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     action,
    input  logic [NODE_W-1:0]        node_a,
    input  logic [NODE_W-1:0]        node_b,
    input  logic                     is_root,
    input  logic signed [COST_W-1:0] edge_cost,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [ALPHA_W-1:0]       alpha,
    input  logic                     infinite,
    input  logic                     cfg_write,
    input  logic                     cfg_index,
    input  logic [COST_W-1:0]        cfg_data,
    output int                       mismatches,
    output int                       pending
);

    typedef struct packed {
        logic [ALPHA_W-1:0] value;
        logic               unbounded;
    } alpha_beat_t;

    logic [NODE_W-1:0]        up_of    [NODE_COUNT];
    logic [DEPTH_W-1:0]       level_of [NODE_COUNT];
    logic signed [COST_W-1:0] toll_of  [NODE_COUNT];
    logic [NODE_W-1:0]        excl_node;
    logic signed [COST_W-1:0] excl_cost;
    alpha_beat_t              alpha_due [$];
    alpha_beat_t              want;

    initial
    begin
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            up_of[i]    = '0;
            level_of[i] = '0;
            toll_of[i]  = '0;
        end
        excl_node  = '0;
        excl_cost  = '0;
        mismatches = 0;
        pending    = 0;
    end

    task automatic report(input string field, input logic [ALPHA_W-1:0] exp_v,
                          input logic [ALPHA_W-1:0] got_v);
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, exp_v, got_v);
        mismatches++;
    endtask

    function automatic void fold_edge(input logic [NODE_W-1:0] n, inout logic have,
                                      inout longint beta);
        longint c;
        if (level_of[n] != '0)
        begin
            c = longint'(toll_of[n]);
            if (!have || c > beta)
            begin
                beta = c;
                have = 1'b1;
            end
        end
    endfunction

    function automatic alpha_beat_t path_alpha(input logic [NODE_W-1:0] a,
                                               input logic [NODE_W-1:0] b,
                                               input logic signed [COST_W-1:0] offer);
        alpha_beat_t       res;
        logic              have;
        logic              broken;
        longint            beta;
        longint            diff;
        logic [NODE_W-1:0] n1;
        logic [NODE_W-1:0] n2;
        int                steps;
        have   = 1'b0;
        broken = 1'b0;
        beta   = 0;
        if (a == b)
            broken = 1'b1;
        else if (up_of[a] == b)
        begin
            beta = longint'(toll_of[a]);
            have = 1'b1;
        end
        else if (up_of[b] == a)
        begin
            beta = longint'(toll_of[b]);
            have = 1'b1;
        end
        else if (a == excl_node || b == excl_node)
        begin
            beta = longint'(excl_cost);
            have = 1'b1;
        end
        else
        begin
            n1    = a;
            n2    = b;
            steps = 0;
            while (up_of[n1] != up_of[n2] && steps < STEP_LIMIT)
            begin
                if (level_of[n1] > level_of[n2])
                begin
                    fold_edge(n1, have, beta);
                    n1 = up_of[n1];
                end
                else
                begin
                    fold_edge(n2, have, beta);
                    n2 = up_of[n2];
                end
                steps++;
            end
            if (up_of[n1] != up_of[n2])
                broken = 1'b1;
            else if (n1 != n2)
            begin
                fold_edge(n1, have, beta);
                fold_edge(n2, have, beta);
            end
        end
        if (broken || !have)
        begin
            res.value     = '1;
            res.unbounded = 1'b1;
        end
        else
        begin
            diff          = longint'(offer) - beta;
            res.value     = (diff > 0) ? diff[ALPHA_W-1:0] : '0;
            res.unbounded = 1'b0;
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (alpha_due.size() == 0)
                    report("unexpected alpha", '0, alpha);
                else
                begin
                    want = alpha_due.pop_front();
                    if (alpha !== want.value)
                        report("alpha", want.value, alpha);
                    if (infinite !== want.unbounded)
                        report("infinite", ALPHA_W'(want.unbounded), ALPHA_W'(infinite));
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == CFG_EXCLUDED_NODE)
                    excl_node = cfg_data[NODE_W-1:0];
                else
                    excl_cost = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                if (action == ACT_QUERY)
                    alpha_due.push_back(path_alpha(node_a, node_b, edge_cost));
                else if (is_root)
                begin
                    up_of[node_a]    = node_a;
                    level_of[node_a] = '0;
                    toll_of[node_a]  = '0;
                end
                else
                begin
                    up_of[node_a]    = node_b;
                    level_of[node_a] = level_of[node_b] + 1'b1;
                    toll_of[node_a]  = edge_cost;
                end
            end
        end
        pending <= alpha_due.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for tree_path_max_alpha: tree loads, alpha queries and the pass/fail verdict.
`timescale 1ns / 1ps

module tb;
    import tpm_pkg::*;

    localparam int ITEMS = 2000;
    localparam logic signed [COST_W-1:0] COST_MIN = 32'sh8000_0000;
    localparam logic signed [COST_W-1:0] COST_MAX = 32'sh7FFF_FFFF;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_stall;
    logic                     action     = ACT_LOAD;
    logic [NODE_W-1:0]        node_a     = '0;
    logic [NODE_W-1:0]        node_b     = '0;
    logic                     is_root    = 1'b0;
    logic signed [COST_W-1:0] edge_cost  = '0;
    logic                     out_valid;
    logic                     out_stall  = 1'b0;
    logic [ALPHA_W-1:0]       alpha;
    logic                     infinite;
    logic                     cfg_write  = 1'b0;
    logic                     cfg_index  = CFG_EXCLUDED_NODE;
    logic [COST_W-1:0]        cfg_data   = '0;

    int mismatches;
    int pending;

    bit                written [NODE_COUNT];
    bit                in_tree [NODE_COUNT];
    logic [NODE_W-1:0] up      [NODE_COUNT];
    logic [NODE_W-1:0] known   [$];
    logic [NODE_W-1:0] tree    [$];
    logic [NODE_W-1:0] cur_excl;
    int                sent       = 0;
    bit                calm       = 1'b0;
    int                stall_left = 0;

    tree_path_max_alpha dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .node_a    (node_a),
        .node_b    (node_b),
        .is_root   (is_root),
        .edge_cost (edge_cost),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .alpha     (alpha),
        .infinite  (infinite),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    alpha_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .node_a     (node_a),
        .node_b     (node_b),
        .is_root    (is_root),
        .edge_cost  (edge_cost),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .alpha      (alpha),
        .infinite   (infinite),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [COST_W-1:0] pick_cost();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return COST_MIN;
        if (r == 1)
            return COST_MAX;
        if (r == 2)
            return COST_W'($signed($urandom_range(0, 10)) - 5);
        return $urandom;
    endfunction

    function automatic logic [NODE_W-1:0] pick_member();
        return tree[$urandom_range(0, tree.size() - 1)];
    endfunction

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    task automatic push_item(input logic act, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b, input logic root,
                             input logic signed [COST_W-1:0] cost);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action    <= act;
        node_a    <= a;
        node_b    <= b;
        is_root   <= root;
        edge_cost <= cost;
        in_valid  <= 1'b1;
        do @(posedge clk); while (in_stall);
        sent++;
        if (act == ACT_LOAD)
        begin
            if (!written[a])
                known.push_back(a);
            written[a] = 1'b1;
            up[a] = root ? a : b;
        end
    endtask

    task automatic load_root(input logic [NODE_W-1:0] a);
        push_item(ACT_LOAD, a, NODE_W'($urandom_range(0, NODE_COUNT - 1)), 1'b1, pick_cost());
    endtask

    task automatic load_child(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                              input logic signed [COST_W-1:0] cost);
        push_item(ACT_LOAD, a, b, 1'b0, cost);
    endtask

    task automatic query(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                         input logic signed [COST_W-1:0] cost);
        push_item(ACT_QUERY, a, b, 1'($urandom_range(0, 1)), cost);
    endtask

    task automatic settle(input int tail);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_regs(input logic [COST_W-1:0] node_word,
                              input logic signed [COST_W-1:0] cost);
        cfg_write <= 1'b1;
        cfg_index <= CFG_EXCLUDED_NODE;
        cfg_data  <= node_word;
        @(posedge clk);
        cfg_index <= CFG_EXCLUDED_COST;
        cfg_data  <= cost;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_excl  = node_word[NODE_W-1:0];
    endtask

    task automatic ask_random();
        int                r;
        logic [NODE_W-1:0] m;
        logic [NODE_W-1:0] other;
        r = $urandom_range(0, 99);
        m = pick_member();
        if (r < 8)
            other = m;
        else if (r < 25)
            other = up[m];
        else if (r < 35 && written[cur_excl])
            other = cur_excl;
        else
            other = pick_member();
        if ($urandom_range(0, 1))
            query(m, other, pick_cost());
        else
            query(other, m, pick_cost());
    endtask

    task automatic run_phase();
        int                budget;
        int                k;
        int                r;
        logic [NODE_W-1:0] x;
        logic [NODE_W-1:0] p;
        calm = ($urandom_range(0, 3) == 0);
        foreach (tree[i])
            in_tree[tree[i]] = 1'b0;
        tree.delete();
        x = NODE_W'($urandom_range(0, NODE_COUNT - 1));
        load_root(x);
        tree.push_back(x);
        in_tree[x] = 1'b1;
        budget = $urandom_range(15, 100);
        while (budget > 0)
        begin
            if (tree.size() > 2 && $urandom_range(0, 2) == 0)
                ask_random();
            else
            begin
                do x = NODE_W'($urandom_range(0, NODE_COUNT - 1)); while (in_tree[x]);
                k = (tree.size() < 3) ? tree.size() : 3;
                if ($urandom_range(0, 1))
                    p = tree[tree.size() - 1 - $urandom_range(0, k - 1)];
                else
                    p = pick_member();
                load_child(x, p, pick_cost());
                tree.push_back(x);
                in_tree[x] = 1'b1;
                budget--;
            end
        end
        settle(8);
        r = $urandom_range(0, 5);
        if (r == 0)
            x = '0;
        else if (r == 1)
            x = '1;
        else if (r == 2)
            x = NODE_W'($urandom_range(0, NODE_COUNT - 1));
        else
            x = pick_member();
        write_regs(($urandom & 32'hFFFF_FC00) | COST_W'(x), pick_cost());
        repeat ($urandom_range(40, 120)) ask_random();
        if ($urandom_range(0, 1))
        begin
            repeat ($urandom_range(1, 3)) load_child(pick_member(), pick_member(), pick_cost());
            if ($urandom_range(0, 1))
                load_root(pick_member());
            query(pick_member(), known[$urandom_range(0, known.size() - 1)], pick_cost());
            repeat ($urandom_range(3, 8)) ask_random();
        end
    endtask

    task automatic wrap_depth();
        logic [NODE_W-1:0] w;
        logic [NODE_W-1:0] c1;
        logic [NODE_W-1:0] c2;
        do w = NODE_W'($urandom_range(0, NODE_COUNT - 1)); while (w == cur_excl);
        do c1 = NODE_W'($urandom_range(0, NODE_COUNT - 1));
        while (c1 == w || c1 == cur_excl);
        do c2 = NODE_W'($urandom_range(0, NODE_COUNT - 1));
        while (c2 == w || c2 == c1 || c2 == cur_excl);
        load_root(w);
        repeat (NODE_COUNT - 1) load_child(w, w, pick_cost());
        load_child(c1, w, pick_cost());
        load_child(c2, w, pick_cost());
        query(c1, c2, pick_cost());
        query(c1, w, pick_cost());
        query(w, c2, pick_cost());
        query(c2, c2, pick_cost());
        load_child(w, w, pick_cost());
        query(c2, c1, pick_cost());
        query(w, c1, pick_cost());
    endtask

    initial
    begin
        #100ms;
        $display("tree_path_max_alpha test failed");
        $finish;
    end

    initial
    begin
        cur_excl = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_regs(32'hFFFF_FFFF, COST_MIN);
        push_item(ACT_LOAD, 10'd0, 10'd1023, 1'b1, COST_MAX);
        load_child(10'd1023, 10'd0, COST_MAX);
        load_child(10'd5, 10'd0, COST_MIN);
        load_child(10'd6, 10'd5, 32'sd100);
        load_child(10'd7, 10'd5, -32'sd3);
        load_child(10'd8, 10'd6, 32'sd50);
        load_child(10'd9, 10'd7, 32'sd50);
        load_child(10'd10, 10'd0, 32'sd0);
        push_item(ACT_LOAD, 10'd20, 10'd0, 1'b1, COST_MIN);
        query(10'd5, 10'd5, 32'sd0);
        query(10'd6, 10'd5, 32'sd150);
        query(10'd5, 10'd6, 32'sd99);
        query(10'd0, 10'd5, COST_MAX);
        query(10'd1023, 10'd8, COST_MIN);
        query(10'd1023, 10'd0, COST_MAX);
        query(10'd8, 10'd9, COST_MIN);
        query(10'd8, 10'd10, 32'sd200);
        query(10'd5, 10'd10, COST_MAX);
        query(10'd6, 10'd7, -32'sd1);
        query(10'd20, 10'd8, 32'sd1);

        while (sent < ITEMS - NODE_COUNT - 64)
            run_phase();
        calm = 1'b0;
        settle(8);
        write_regs(32'h0000_0000, COST_MAX);
        wrap_depth();

        settle(40);
        if (mismatches == 0 && pending == 0)
            $display("tree_path_max_alpha test passed");
        else
            $display("tree_path_max_alpha test failed");
        $finish;
    end

endmodule
